@@ hw/rtl/great_circle_bearing_macros.svh @@
// assertion macros for the great circle bearing block
// expects clk and arst_n in the including scope
`ifndef GREAT_CIRCLE_BEARING_MACROS_SVH
`define GREAT_CIRCLE_BEARING_MACROS_SVH

// same-cycle implication
`define GCB_ASSERT_HOLDS(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define GCB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/gcb_pkg.sv @@
// shared types and constants for the great circle bearing pipeline
// no dependencies
package gcb_pkg;

	localparam int CORDIC_STEPS      = 24;
	localparam int BEARING_FRAC_BITS = 16;
	localparam int VEC_FRAC          = 30;
	localparam int LANES             = 3;

	// angles with 29 fraction bits
	localparam logic signed [33:0] PI_ANG      = 34'sd1686629713;
	localparam logic signed [33:0] HALF_PI_ANG = 34'sd843314857;
	localparam logic signed [33:0] TWO_PI_ANG  = 34'sd3373259426;

	// cordic gain compensation, 30 fraction bits
	localparam logic signed [31:0] GAIN_COMP = 32'sd652032874;

	// 180/pi scaled by 2^43, applied with a 56 bit shift
	localparam logic [48:0] DEG_SCALE = 49'd503979006376991;
	localparam logic [24:0] DEG_SCALE_LO = DEG_SCALE[24:0];
	localparam logic [23:0] DEG_SCALE_HI = DEG_SCALE[48:25];

	localparam logic [25:0] BEAR_FULL = 26'(360) << BEARING_FRAC_BITS;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic               flip;
	} rot_t;

	typedef struct packed {
		logic signed [31:0] s;
		logic signed [31:0] c;
	} sc_t;

	typedef struct packed {
		logic signed [33:0] x;
		logic signed [33:0] y;
		logic signed [32:0] z;
		logic               zero;
	} vec_t;

	// atan(2^-i), 29 fraction bits
	function automatic logic signed [31:0] atan_ang(input logic [4:0] i);
		case (i)
			5'd0:    return 32'sd421657428;
			5'd1:    return 32'sd248918915;
			5'd2:    return 32'sd131521918;
			5'd3:    return 32'sd66762579;
			5'd4:    return 32'sd33510843;
			5'd5:    return 32'sd16771758;
			5'd6:    return 32'sd8387925;
			5'd7:    return 32'sd4194219;
			5'd8:    return 32'sd2097141;
			5'd9:    return 32'sd1048575;
			5'd10:   return 32'sd524288;
			5'd11:   return 32'sd262144;
			5'd12:   return 32'sd131072;
			5'd13:   return 32'sd65536;
			5'd14:   return 32'sd32768;
			5'd15:   return 32'sd16384;
			5'd16:   return 32'sd8192;
			5'd17:   return 32'sd4096;
			5'd18:   return 32'sd2048;
			5'd19:   return 32'sd1024;
			5'd20:   return 32'sd512;
			5'd21:   return 32'sd256;
			5'd22:   return 32'sd128;
			5'd23:   return 32'sd64;
			default: return 32'sd0;
		endcase
	endfunction

endpackage

@@ hw/rtl/gcb_sincos.sv @@
// three-lane rotation cordic: range reduction, fold and one stage per step
// depends on gcb_pkg
module gcb_sincos import gcb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_vld,
	input  logic signed [33:0] ang [LANES],
	output logic               out_vld,
	output sc_t                sc [LANES]
);

	logic                    vld_s1;
	logic                    vld_s2;
	logic [CORDIC_STEPS-1:0] vld_rot;
	logic signed [33:0]      red_s1 [LANES];
	rot_t                    rot_s [LANES][CORDIC_STEPS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_rot <= '0;
			out_vld <= 1'b0;
		end else if (en) begin
			vld_s1  <= in_vld;
			vld_s2  <= vld_s1;
			vld_rot <= {vld_rot[CORDIC_STEPS-2:0], vld_s2};
			out_vld <= vld_rot[CORDIC_STEPS-1];
		end
	end

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		logic signed [33:0] red_n;
		rot_t               fold_n;

		// remainder towards zero by a full turn
		always_comb begin
			if (ang[l] >= TWO_PI_ANG) begin
				red_n = ang[l] - TWO_PI_ANG;
			end else if (ang[l] <= -TWO_PI_ANG) begin
				red_n = ang[l] + TWO_PI_ANG;
			end else begin
				red_n = ang[l];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				red_s1[l] <= red_n;
			end
		end

		// wrap into half a turn either side, then fold into the right half plane
		always_comb begin : fold
			logic signed [33:0] w;
			logic signed [33:0] v;
			if (red_s1[l] > PI_ANG) begin
				w = red_s1[l] - TWO_PI_ANG;
			end else if (red_s1[l] < -PI_ANG) begin
				w = red_s1[l] + TWO_PI_ANG;
			end else begin
				w = red_s1[l];
			end
			fold_n.x    = GAIN_COMP;
			fold_n.y    = '0;
			fold_n.flip = 1'b0;
			if (w > HALF_PI_ANG) begin
				v           = w - PI_ANG;
				fold_n.flip = 1'b1;
			end else if (w < -HALF_PI_ANG) begin
				v           = w + PI_ANG;
				fold_n.flip = 1'b1;
			end else begin
				v = w;
			end
			fold_n.z = v[31:0];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rot_s[l][0] <= fold_n;
			end
		end

		for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
			rot_t nxt;

			always_comb begin
				nxt = rot_s[l][k];
				if (rot_s[l][k].z >= 0) begin
					nxt.x = rot_s[l][k].x - (rot_s[l][k].y >>> k);
					nxt.y = rot_s[l][k].y + (rot_s[l][k].x >>> k);
					nxt.z = rot_s[l][k].z - atan_ang(5'(k));
				end else begin
					nxt.x = rot_s[l][k].x + (rot_s[l][k].y >>> k);
					nxt.y = rot_s[l][k].y - (rot_s[l][k].x >>> k);
					nxt.z = rot_s[l][k].z + atan_ang(5'(k));
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					rot_s[l][k+1] <= nxt;
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sc[l].s <= rot_s[l][CORDIC_STEPS].flip ? -rot_s[l][CORDIC_STEPS].y
					: rot_s[l][CORDIC_STEPS].y;
				sc[l].c <= rot_s[l][CORDIC_STEPS].flip ? -rot_s[l][CORDIC_STEPS].x
					: rot_s[l][CORDIC_STEPS].x;
			end
		end
	end

endmodule

@@ hw/rtl/gcb_mult.sv @@
// products forming the atan2 arguments, three register stages
// depends on gcb_pkg
module gcb_mult import gcb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_vld,
	input  sc_t                sc [LANES],
	output logic               out_vld,
	output logic signed [32:0] y_out,
	output logic signed [32:0] x_out
);

	function automatic logic signed [31:0] rmul(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic signed [63:0] p;
		p = a * b;
		p = p + (64'sd1 <<< (VEC_FRAC - 1));
		return p[61:30];
	endfunction

	logic               vld_s1, vld_s2;
	logic signed [31:0] y_s1, p_s1, t_s1, cd_s1;
	logic signed [31:0] y_s2, p_s2, u_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			out_vld <= 1'b0;
		end else if (en) begin
			vld_s1  <= in_vld;
			vld_s2  <= vld_s1;
			out_vld <= vld_s2;
		end
	end

	// lane 0 start latitude, lane 1 end latitude, lane 2 longitude difference
	always_ff @(posedge clk) begin
		if (en) begin
			y_s1  <= rmul(sc[2].s, sc[1].c);
			p_s1  <= rmul(sc[0].c, sc[1].s);
			t_s1  <= rmul(sc[0].s, sc[1].c);
			cd_s1 <= sc[2].c;
			y_s2  <= y_s1;
			p_s2  <= p_s1;
			u_s2  <= rmul(t_s1, cd_s1);
			y_out <= 33'(y_s2);
			x_out <= 33'(p_s2) - 33'(u_s2);
		end
	end

endmodule

@@ hw/rtl/gcb_atan.sv @@
// vectoring cordic for atan2, quadrant pre-rotation then one stage per step
// depends on gcb_pkg
module gcb_atan import gcb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_vld,
	input  logic signed [32:0] y_in,
	input  logic signed [32:0] x_in,
	output logic               out_vld,
	output logic signed [32:0] z_out,
	output logic               zero_out
);

	logic [CORDIC_STEPS:0] vld_s;
	vec_t                  vec_s [CORDIC_STEPS+1];
	vec_t                  pre_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[CORDIC_STEPS-1:0], in_vld};
		end
	end

	always_comb begin
		pre_n.zero = (x_in == 0) && (y_in == 0);
		if (x_in < 0) begin
			pre_n.z = (y_in >= 0) ? 33'(PI_ANG) : 33'(-PI_ANG);
			pre_n.x = -34'(x_in);
			pre_n.y = -34'(y_in);
		end else begin
			pre_n.z = '0;
			pre_n.x = 34'(x_in);
			pre_n.y = 34'(y_in);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vec_s[0] <= pre_n;
		end
	end

	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
		vec_t nxt;

		always_comb begin
			nxt = vec_s[k];
			if (vec_s[k].y >= 0) begin
				nxt.x = vec_s[k].x + (vec_s[k].y >>> k);
				nxt.y = vec_s[k].y - (vec_s[k].x >>> k);
				nxt.z = vec_s[k].z + atan_ang(5'(k));
			end else begin
				nxt.x = vec_s[k].x - (vec_s[k].y >>> k);
				nxt.y = vec_s[k].y + (vec_s[k].x >>> k);
				nxt.z = vec_s[k].z - atan_ang(5'(k));
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				vec_s[k+1] <= nxt;
			end
		end
	end

	assign out_vld  = vld_s[CORDIC_STEPS];
	assign z_out    = vec_s[CORDIC_STEPS].z;
	assign zero_out = vec_s[CORDIC_STEPS].zero;

endmodule

@@ hw/rtl/gcb_deg.sv @@
// radians to degrees with rounding, then wrap into one turn
// depends on gcb_pkg
module gcb_deg import gcb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_vld,
	input  logic signed [32:0] z_in,
	input  logic               zero_in,
	output logic               out_vld,
	output logic [24:0]        bearing
);

	logic        vld_s1, vld_s2, vld_s3;
	logic        neg_s1, neg_s2, neg_s3;
	logic        zero_s1, zero_s2, zero_s3;
	logic [31:0] mag_s1;
	logic [56:0] plo_s2;
	logic [55:0] phi_s2;
	logic [25:0] mag_s3;
	logic [81:0] sum;
	logic [24:0] deg_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			out_vld <= 1'b0;
		end else if (en) begin
			vld_s1  <= in_vld;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			out_vld <= vld_s3;
		end
	end

	assign sum = 82'({phi_s2, 25'b0}) + 82'(plo_s2) + (82'(1) << 55);

	always_comb begin
		if (zero_s3) begin
			deg_n = '0;
		end else if (neg_s3) begin
			if (mag_s3 == 0 || mag_s3 > BEAR_FULL) begin
				deg_n = '0;
			end else begin
				deg_n = 25'(BEAR_FULL - mag_s3);
			end
		end else if (mag_s3 >= BEAR_FULL) begin
			deg_n = 25'(BEAR_FULL - 26'd1);
		end else begin
			deg_n = mag_s3[24:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1  <= z_in < 0;
			zero_s1 <= zero_in;
			mag_s1  <= (z_in < 0) ? 32'(-z_in) : 32'(z_in);
			neg_s2  <= neg_s1;
			zero_s2 <= zero_s1;
			plo_s2  <= mag_s1 * DEG_SCALE_LO;
			phi_s2  <= mag_s1 * DEG_SCALE_HI;
			neg_s3  <= neg_s2;
			zero_s3 <= zero_s2;
			mag_s3  <= sum[81:56];
			bearing <= deg_n;
		end
	end

endmodule

@@ hw/rtl/great_circle_bearing.sv @@
// top level of the great circle initial bearing pipeline
// depends on gcb_pkg, gcb_sincos, gcb_mult, gcb_atan, gcb_deg and the macro header
//
// usage
//   s_axis carries one request: start and end latitude and longitude, radians,
//   signed with 29 fraction bits. m_axis returns the initial bearing in degrees,
//   0 to below 360, unsigned with 16 fraction bits.
//   a request is taken on any edge with tvalid and tready high; one request per
//   cycle is sustained while m_axis takes results, and each gives exactly one result.
//   the path to m_axis_tvalid runs through range reduction, the rotation cordic,
//   the products, the vectoring cordic and conversion; each cordic has 24 steps.
//   the output register has a one-entry skid behind it: when m_axis stalls the
//   pipeline moves on until the skid is full, then s_axis_tready drops until
//   the receiver takes the held result. nothing is dropped or repeated.
//   reset clears every valid bit; s_axis_tready is already high when reset is
//   released, so a request can be taken at the first edge after release.
`include "great_circle_bearing_macros.svh"

module great_circle_bearing import gcb_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// start_latitude[30:0], start_longitude[62:31], end_latitude[93:63],
	// end_longitude[125:94], zero pad
	input  logic [127:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// bearing_degrees[24:0], zero pad
	output logic [31:0]  m_axis_tdata
);

	logic               en;
	logic signed [33:0] ang [LANES];
	logic               sc_vld;
	sc_t                sc [LANES];
	logic               xy_vld;
	logic signed [32:0] y_v, x_v;
	logic               z_vld;
	logic signed [32:0] z_v;
	logic               z_zero;
	logic               p_vld;
	logic [24:0]        p_deg;
	logic               out_vld_q, skid_vld_q;
	logic [24:0]        out_q, skid_q;

	assign en            = ~skid_vld_q;
	assign s_axis_tready = en;

	assign ang[0] = 34'(signed'(s_axis_tdata[30:0]));
	assign ang[1] = 34'(signed'(s_axis_tdata[93:63]));
	assign ang[2] = 34'(signed'(s_axis_tdata[125:94])) - 34'(signed'(s_axis_tdata[62:31]));

	gcb_sincos u_sincos (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (s_axis_tvalid),
		.ang     (ang),
		.out_vld (sc_vld),
		.sc      (sc)
	);

	gcb_mult u_mult (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (sc_vld),
		.sc      (sc),
		.out_vld (xy_vld),
		.y_out   (y_v),
		.x_out   (x_v)
	);

	gcb_atan u_atan (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (xy_vld),
		.y_in     (y_v),
		.x_in     (x_v),
		.out_vld  (z_vld),
		.z_out    (z_v),
		.zero_out (z_zero)
	);

	gcb_deg u_deg (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (z_vld),
		.z_in    (z_v),
		.zero_in (z_zero),
		.out_vld (p_vld),
		.bearing (p_deg)
	);

	// output register with skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!out_vld_q || m_axis_tready) begin
			if (skid_vld_q) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= p_vld;
			end
		end else if (p_vld && !skid_vld_q) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || m_axis_tready) begin
			out_q <= skid_vld_q ? skid_q : p_deg;
		end
		if (out_vld_q && !m_axis_tready && !skid_vld_q) begin
			skid_q <= p_deg;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {7'b0, out_q};

	`GCB_ASSERT_HOLDS(a_skid_behind_out, skid_vld_q, out_vld_q, "skid full with empty output")
	`GCB_ASSERT_NEXT(a_skid_drains, skid_vld_q && m_axis_tready, out_vld_q && !skid_vld_q, "skid not drained")
	`GCB_ASSERT_HOLDS(a_bearing_range, out_vld_q, out_q < BEAR_FULL, "bearing beyond one turn")

endmodule

@@ tb/great_circle_bearing_tb.sv @@
// self-checking testbench for the great circle bearing pipeline
// depends on great_circle_bearing, which uses gcb_pkg; predicts each bearing with its own cordic model
module great_circle_bearing_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT = 400000;
	localparam int STEPS = 24;
	localparam int BFRAC = 16;

	typedef struct packed {
		logic [31:0] lon2;
		logic [30:0] lat2;
		logic [31:0] lon1;
		logic [30:0] lat1;
	} posn_pair_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [127:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;

	posn_pair_t  pending_req[$];
	logic [24:0] bearing_expected[$];
	int          send_idle, recv_idle, recv_hold, errors, cycles;
	bit          send_pause;

	longint      atan_tab[30];
	longint      pi_wide, pi_a, half_pi_a, two_pi_a, gain_k;

	great_circle_bearing u_top (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #5 clk = ~clk;

	function automatic longint atan_series(longint unsigned n);
		longint unsigned pw, nn, k;
		longint sum, t;
		pw = (64'd1 << 60) / n;
		nn = n * n;
		k = 0;
		sum = 0;
		while (pw != 0) begin
			t = longint'(pw / (2 * k + 1));
			sum += k[0] ? -t : t;
			pw /= nn;
			k++;
		end
		return sum;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic longint to_angle(longint v);
		return (v + (64'sd1 <<< 30)) >>> 31;
	endfunction

	task automatic build_tables();
		longint quarter;
		longint unsigned k2;
		quarter = 4 * atan_series(5) - atan_series(239);
		pi_wide = 4 * quarter;
		for (int i = 0; i < 30; i++)
			atan_tab[i] = to_angle(i == 0 ? quarter : atan_series(64'd1 << i));
		pi_a = to_angle(pi_wide);
		half_pi_a = to_angle(pi_wide / 2);
		two_pi_a = 2 * pi_a;
		k2 = 64'd1 << 62;
		for (int i = 0; i < STEPS; i++)
			k2 -= k2 / ((64'd1 << (2 * i)) + 1);
		gain_k = longint'((int_sqrt(k2) + 1) >> 1);
	endtask

	function automatic void rotate_sincos(input longint ang, output longint s,
			output longint c);
		longint x, y, z, xs, ys;
		bit flip;
		x = gain_k;
		y = 0;
		flip = 0;
		z = ang % two_pi_a;
		if (z > pi_a) z -= two_pi_a;
		if (z < -pi_a) z += two_pi_a;
		if (z > half_pi_a) begin
			z -= pi_a;
			flip = 1;
		end else if (z < -half_pi_a) begin
			z += pi_a;
			flip = 1;
		end
		for (int i = 0; i < STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x -= ys; y += xs; z -= atan_tab[i];
			end else begin
				x += ys; y -= xs; z += atan_tab[i];
			end
		end
		s = flip ? -y : y;
		c = flip ? -x : x;
	endfunction

	function automatic longint fx_mul(longint a, longint b);
		return (a * b + (64'sd1 <<< 29)) >>> 30;
	endfunction

	function automatic longint vector_atan2(longint y, longint x);
		longint z, xs, ys;
		z = 0;
		if (x < 0) begin
			z = (y >= 0) ? pi_a : -pi_a;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x += ys; y -= xs; z += atan_tab[i];
			end else begin
				x -= ys; y += xs; z -= atan_tab[i];
			end
		end
		return z;
	endfunction

	function automatic logic [24:0] predict_bearing(posn_pair_t p);
		longint s1, c1, s2, c2, sd, cd, y, x, z, deg, full;
		longint unsigned mag, q, r, d;
		rotate_sincos(longint'($signed(p.lat1)), s1, c1);
		rotate_sincos(longint'($signed(p.lat2)), s2, c2);
		rotate_sincos(longint'($signed(p.lon2)) - longint'($signed(p.lon1)), sd, cd);
		y = fx_mul(sd, c2);
		x = fx_mul(c1, s2) - fx_mul(fx_mul(s1, c2), cd);
		if (x == 0 && y == 0) return '0;
		z = vector_atan2(y, x);
		mag = longint'(z < 0 ? -z : z) * 180;
		d = pi_wide;
		q = mag / d;
		r = mag % d;
		for (int i = 0; i < BFRAC + 60 + 1 - 29; i++) begin
			r <<= 1;
			q <<= 1;
			if (r >= d) begin
				r -= d;
				q |= 1;
			end
		end
		mag = (q + 1) >> 1;
		full = longint'(360) << BFRAC;
		deg = (z < 0) ? -longint'(mag) : longint'(mag);
		if (deg < 0) deg += full;
		if (deg < 0) deg = 0;
		if (deg >= full) deg = full - 1;
		return deg[24:0];
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (s_axis_tvalid)
				bearing_expected.push_back(predict_bearing(posn_pair_t'(s_axis_tdata[125:0])));
			if (pending_req.size() > 0 && !send_pause && $urandom_range(99) >= send_idle) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= {2'b00, pending_req.pop_front()};
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (bearing_expected.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected bearing %0d", m_axis_tdata[24:0]);
				end else if (m_axis_tdata[24:0] !== bearing_expected[0]) begin
					errors++;
					if (errors <= 10)
						$display("bearing mismatch: expected %0d actual %0d",
							bearing_expected[0], m_axis_tdata[24:0]);
					void'(bearing_expected.pop_front());
				end else begin
					void'(bearing_expected.pop_front());
				end
			end
			m_axis_tready <= (recv_hold == 0) && ($urandom_range(99) >= recv_idle);
		end
	end

	// long receiver hold-off
	always @(posedge clk)
		if (recv_hold > 0) recv_hold <= recv_hold - 1;

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic logic [30:0] rand_lat(bit wide);
		if (wide) return 31'($urandom);
		return 31'($signed($urandom_range(2 * 843314857)) - 843314857);
	endfunction

	function automatic logic [31:0] rand_lon(bit wide);
		if (wide) return $urandom;
		return 32'(longint'($urandom_range(32'd3373259426)) - 1686629713);
	endfunction

	task automatic add_req(logic [30:0] la1, logic [31:0] lo1, logic [30:0] la2,
			logic [31:0] lo2);
		posn_pair_t p;
		p.lat1 = la1; p.lon1 = lo1; p.lat2 = la2; p.lon2 = lo2;
		pending_req.push_back(p);
	endtask

	task automatic add_random(int n);
		bit wide;
		for (int i = 0; i < n; i++) begin
			wide = ($urandom_range(9) == 0);
			if ($urandom_range(9) == 0)
				add_req(rand_lat(wide), rand_lon(wide), rand_lat(wide), rand_lon(wide));
			else
				add_req(rand_lat(wide), rand_lon(wide), rand_lat(0), rand_lon(0));
		end
	endtask

	task automatic wait_drained();
		while (pending_req.size() > 0 || s_axis_tvalid || bearing_expected.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		errors = 0;
		cycles = 0;
		recv_hold = 0;
		send_pause = 0;
		send_idle = 15;
		recv_idle = 87;
		build_tables();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// same point, poles, due north, south, east and west, extremes, wraps past pi
		add_req(0, 0, 0, 0);
		add_req(31'sd843314857, 0, 31'sd843314857, 0);
		add_req(0, 0, 31'sd100000000, 0);
		add_req(31'sd100000000, 0, 0, 0);
		add_req(0, 0, 0, 32'sd100000000);
		add_req(0, 32'sd100000000, 0, 0);
		add_req(-31'sd843314857, 32'sd1686629713, 31'sd843314857, -32'sd1686629713);
		add_req(31'sd843314857, -32'sd1686629713, -31'sd843314857, 32'sd1686629713);
		add_req(0, -32'sd1686629713, 0, 32'sd1686629713);
		add_req(31'sd200000000, 32'sd1686629713, -31'sd300000000, -32'sd1686629713);
		add_req(31'h3fffffff, 32'h7fffffff, 31'h40000000, 32'h80000000);
		add_req(31'h40000000, 32'h80000000, 31'h3fffffff, 32'h7fffffff);
		add_req(31'h7fffffff, 32'hffffffff, 31'h7fffffff, 32'h00000000);
		add_req(31'sd12345678, 32'sd1000, 31'sd12345678, -32'sd1000);
		add_req(-31'sd843314857, 0, 31'sd1, 32'sd1);
		add_req(0, 0, -31'sd1, 0);
		add_random(400);
		wait_drained();

		send_idle = 87;
		recv_idle = 15;
		add_random(400);
		wait_drained();

		send_idle = 0;
		recv_idle = 0;
		recv_hold = 300;
		add_random(200);
		wait_drained();
		send_pause = 1;
		add_random(50);
		repeat (20) @(posedge clk);
		send_pause = 0;
		add_random(200);
		wait_drained();
		repeat (70) @(posedge clk);

		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
